@@ sv/udm_pkg.sv @@
// Package for the unambiguous delta-R matcher: widths, codes, shared types.
// No dependencies; udm_if, udm_dist and the top level import it.
`timescale 1ns / 1ps

package udm_pkg;

  localparam int MAX_TARGETS = 32;
  localparam int MAX_SOURCES = 32;

  localparam int TI_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int SI_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int TC_W = $clog2(MAX_TARGETS + 1);
  localparam int SC_W = $clog2(MAX_SOURCES + 1);

  localparam int OP_W     = 2;
  localparam int ETA_W    = 12;
  localparam int PHI_W    = 10;
  localparam int FLAV_W   = 8;
  localparam int TIDX_W   = 6;
  localparam int STAT_W   = 2;
  localparam int SIDX_W   = 7;
  localparam int DR_W     = 23;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // shared squaring unit
  localparam int MUL_W    = ETA_W;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ACC_W    = PROD_W + 1;
  localparam logic [PHI_W-1:0] PHI_HALF = PHI_W'(1 << (PHI_W - 1));

  localparam logic [DR_W-1:0] DR_RESET = DR_W'(1062);

  localparam logic [APB_AW-3:0] REG_MAX_DR = '0;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_TGT = 2'd0,
    OP_LOAD_SRC = 2'd1,
    OP_RUN      = 2'd2,
    OP_NONE     = 2'd3
  } opcode_t;

  localparam logic [STAT_W-1:0] ST_NONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_MATCHED = 2'd1;
  localparam logic [STAT_W-1:0] ST_AMBIG   = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd3;

  // hit count kept as zero, one or many
  localparam logic [1:0] HITS_ZERO = 2'd0;
  localparam logic [1:0] HITS_ONE  = 2'd1;
  localparam logic [1:0] HITS_MANY = 2'd2;

  typedef struct packed {
    logic load_diff;  // capture |d eta| and wrapped |d phi|
    logic sq_eta;     // acc = |d eta|^2
    logic sq_phi;     // acc += |d phi|^2
  } dist_ctl_t;

  function automatic logic [1:0] hits_inc(input logic [1:0] h);
    logic [1:0] r;
    r = (h == HITS_ZERO) ? HITS_ONE : HITS_MANY;
    return r;
  endfunction

endpackage

@@ sv/udm_if.sv @@
// Handshake channel interfaces for input requests and result items.
// Depends on udm_pkg for the field widths.
`timescale 1ns / 1ps

interface udm_item_if;
  import udm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic signed [ETA_W-1:0]  eta;
  logic [PHI_W-1:0]         phi;
  logic signed [FLAV_W-1:0] flavour;

  modport source (output valid, opcode, eta, phi, flavour, input ready);
  modport sink   (input valid, opcode, eta, phi, flavour, output ready);
endinterface

interface udm_result_if;
  import udm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [TIDX_W-1:0]        target_index;
  logic signed [FLAV_W-1:0] label;
  logic [STAT_W-1:0]        status;
  logic signed [SIDX_W-1:0] source_index;
  logic                     overflow;
  logic                     last;

  modport source (output valid, target_index, label, status, source_index, overflow, last,
                  input ready);
  modport sink   (input valid, target_index, label, status, source_index, overflow, last,
                  output ready);
endinterface

@@ sv/udm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module udm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/udm_dist.sv @@
// Shared distance unit: one squarer used twice per pair, accumulator, radius compare.
// Depends on udm_pkg.
`timescale 1ns / 1ps

module udm_dist (
  input  logic                          clk,
  input  logic                          rst,
  input  udm_pkg::dist_ctl_t            ctl,
  input  logic signed [udm_pkg::ETA_W-1:0] t_eta,
  input  logic [udm_pkg::PHI_W-1:0]     t_phi,
  input  logic signed [udm_pkg::ETA_W-1:0] s_eta,
  input  logic [udm_pkg::PHI_W-1:0]     s_phi,
  input  logic [udm_pkg::DR_W-1:0]      max_dr,
  output logic                          hit
);
  import udm_pkg::*;

  logic signed [ETA_W:0] de;
  logic [ETA_W:0]        de_abs;
  logic [PHI_W-1:0]      dp_raw;
  logic [PHI_W-1:0]      dp_fold;
  logic [ETA_W-1:0]      deta;
  logic [PHI_W-1:0]      dphi;
  logic [MUL_W-1:0]      mul_op;
  logic [PROD_W-1:0]     prod;
  logic [ACC_W-1:0]      acc;

  always_comb begin
    de      = {t_eta[ETA_W-1], t_eta} - {s_eta[ETA_W-1], s_eta};
    de_abs  = de[ETA_W] ? (~de + (ETA_W+1)'(1)) : de;
    dp_raw  = t_phi - s_phi;
    dp_fold = (dp_raw > PHI_HALF) ? (~dp_raw + PHI_W'(1)) : dp_raw;
    mul_op  = ctl.sq_phi ? MUL_W'(dphi) : deta;
    prod    = PROD_W'(mul_op) * PROD_W'(mul_op);
    hit     = acc < ACC_W'(max_dr);
  end

  always_ff @(posedge clk) begin
    if (ctl.load_diff) begin
      deta <= de_abs[ETA_W-1:0];
      dphi <= dp_fold;
    end
    if (ctl.sq_eta) begin
      acc <= ACC_W'(prod);
    end else if (ctl.sq_phi) begin
      acc <= acc + ACC_W'(prod);
    end
  end

`ifndef SYNTHESIS
  a_ctl_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.load_diff, ctl.sq_eta, ctl.sq_phi}))
    else $error("distance unit steps overlap");
  a_phi_folded: assert property (@(posedge clk) disable iff (rst)
    ctl.sq_phi |-> dphi <= PHI_HALF)
    else $error("wrapped phi difference above half turn");
  a_acc_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.sq_phi |=> acc >= $past(acc))
    else $error("accumulator shrank on phi square");
`endif

endmodule

@@ sv/unambiguous_delta_r_matcher_top.sv @@
// Top level of the unambiguous delta-R matcher: APB register, load/run sequencer,
// hit bookkeeping and result register. Depends on udm_pkg, udm_if, udm_ram, udm_dist.
`timescale 1ns / 1ps

// Usage:
//  items   : request channel (valid/ready). opcode 0 loads a target jet (eta, phi),
//            opcode 1 loads a source jet (eta, phi, flavour), opcode 2 runs the match,
//            opcode 3 is ignored. Loads past 32 entries are dropped and raise overflow.
//  results : one item per loaded target, in load order, last set on the final one.
//  APB     : register max_dr_squared at byte address 0, strict less-than radius.
//  Loads   : ready stays high in between loads while no run is active.
//  A run walks every pair (T targets, S sources) through the one shared squarer
//  in five steps: RAM read wait, difference capture, eta square, phi square and
//  accumulate, radius compare. Each result then takes a source RAM read and an
//  output load, and a last step clears the loaded counts; ready is low for the
//  whole run.
//  A stalled receiver holds the current result in the output register and
//  freezes the emit walk until it is taken; the final result may still wait
//  there while new loads are taken.
//  Reset: empties both stores, clears overflow, restores the radius to 1062 and
//  drops any pending result. Store contents need no clearing pass.
module unambiguous_delta_r_matcher_top (
  input  logic                         clk,
  input  logic                         rst,
  udm_item_if.sink                     items,
  udm_result_if.source                 results,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [udm_pkg::APB_AW-1:0]   paddr,
  input  logic [udm_pkg::APB_DW-1:0]   pwdata,
  output logic [udm_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import udm_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_RUN_INIT = 10'b0000000010,
    S_WAIT     = 10'b0000000100,
    S_DIFF     = 10'b0000001000,
    S_SQ_ETA   = 10'b0000010000,
    S_SQ_PHI   = 10'b0000100000,
    S_CMP      = 10'b0001000000,
    S_EMIT_RD  = 10'b0010000000,
    S_EMIT_OUT = 10'b0100000000,
    S_CLEAR    = 10'b1000000000
  } state_t;

  localparam int TGT_W = ETA_W + PHI_W;
  localparam int SRC_W = ETA_W + PHI_W + FLAV_W;

  state_t state, state_next;

  logic [DR_W-1:0] max_dr;
  logic [TC_W-1:0] tgt_cnt;
  logic [SC_W-1:0] src_cnt;
  logic            ovf;
  logic [TI_W-1:0] ti;
  logic [SI_W-1:0] sj;

  logic [1:0]      thits [MAX_TARGETS];
  logic [1:0]      shits [MAX_SOURCES];
  logic [SI_W-1:0] cand  [MAX_TARGETS];

  logic            accept;
  logic            cfg_wr;
  logic            tgt_we;
  logic            src_we;
  logic            emitting;
  logic [SI_W-1:0] s_raddr;
  logic [TGT_W-1:0] tgt_rdata;
  logic [SRC_W-1:0] src_rdata;
  logic            hit;
  logic            last_src;
  logic            last_tgt;
  logic            out_load;
  dist_ctl_t       dctl;

  logic signed [ETA_W-1:0]  t_eta;
  logic [PHI_W-1:0]         t_phi;
  logic signed [ETA_W-1:0]  s_eta;
  logic [PHI_W-1:0]         s_phi;
  logic signed [FLAV_W-1:0] s_flav;

  logic                     res_valid;
  logic [TIDX_W-1:0]        res_tidx;
  logic signed [FLAV_W-1:0] res_label;
  logic [STAT_W-1:0]        res_status;
  logic signed [SIDX_W-1:0] res_sidx;
  logic                     res_ovf;
  logic                     res_last;

  logic [STAT_W-1:0]        new_status;
  logic signed [FLAV_W-1:0] new_label;
  logic signed [SIDX_W-1:0] new_sidx;

  // configuration port: always ready, write on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    prdata = '0;
    if (paddr[APB_AW-1:2] == REG_MAX_DR) begin
      prdata = APB_DW'(max_dr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_dr <= DR_RESET;
    end else if (cfg_wr && paddr[APB_AW-1:2] == REG_MAX_DR) begin
      max_dr <= pwdata[DR_W-1:0];
    end
  end

  // requests are taken only between runs
  assign items.ready = (state == S_IDLE);
  assign accept      = items.valid && items.ready;
  assign tgt_we = accept && items.opcode == OP_LOAD_TGT && tgt_cnt < TC_W'(MAX_TARGETS);
  assign src_we = accept && items.opcode == OP_LOAD_SRC && src_cnt < SC_W'(MAX_SOURCES);

  // the source RAM and hit table follow the candidate while emitting
  assign emitting = (state == S_EMIT_RD) || (state == S_EMIT_OUT);
  assign s_raddr  = emitting ? cand[ti] : sj;

  udm_ram #(.WIDTH(TGT_W), .DEPTH(MAX_TARGETS)) u_tgt_ram (
    .clk   (clk),
    .we    (tgt_we),
    .waddr (tgt_cnt[TI_W-1:0]),
    .wdata ({items.eta, items.phi}),
    .raddr (ti),
    .rdata (tgt_rdata)
  );

  udm_ram #(.WIDTH(SRC_W), .DEPTH(MAX_SOURCES)) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (src_cnt[SI_W-1:0]),
    .wdata ({items.eta, items.phi, items.flavour}),
    .raddr (s_raddr),
    .rdata (src_rdata)
  );

  assign {t_eta, t_phi}         = tgt_rdata;
  assign {s_eta, s_phi, s_flav} = src_rdata;

  assign dctl.load_diff = (state == S_DIFF);
  assign dctl.sq_eta    = (state == S_SQ_ETA);
  assign dctl.sq_phi    = (state == S_SQ_PHI);

  udm_dist u_dist (
    .clk    (clk),
    .rst    (rst),
    .ctl    (dctl),
    .t_eta  (t_eta),
    .t_phi  (t_phi),
    .s_eta  (s_eta),
    .s_phi  (s_phi),
    .max_dr (max_dr),
    .hit    (hit)
  );

  assign last_src = (SC_W'(sj) + SC_W'(1)) == src_cnt;
  assign last_tgt = (TC_W'(ti) + TC_W'(1)) == tgt_cnt;
  assign out_load = (state == S_EMIT_OUT) && (!res_valid || results.ready);

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && items.opcode == OP_RUN) begin
          state_next = S_RUN_INIT;
        end
      end
      S_RUN_INIT: begin
        if (tgt_cnt == '0) begin
          state_next = S_CLEAR;
        end else if (src_cnt == '0) begin
          state_next = S_EMIT_RD;
        end else begin
          state_next = S_WAIT;
        end
      end
      S_WAIT:   state_next = S_DIFF;
      S_DIFF:   state_next = S_SQ_ETA;
      S_SQ_ETA: state_next = S_SQ_PHI;
      S_SQ_PHI: state_next = S_CMP;
      S_CMP: begin
        state_next = (last_src && last_tgt) ? S_EMIT_RD : S_WAIT;
      end
      S_EMIT_RD: state_next = S_EMIT_OUT;
      S_EMIT_OUT: begin
        if (out_load) begin
          state_next = last_tgt ? S_CLEAR : S_EMIT_RD;
        end
      end
      S_CLEAR: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      tgt_cnt <= '0;
      src_cnt <= '0;
      ovf     <= 1'b0;
      ti      <= '0;
      sj      <= '0;
      for (int k = 0; k < MAX_TARGETS; k++) begin
        thits[k] <= HITS_ZERO;
      end
      for (int k = 0; k < MAX_SOURCES; k++) begin
        shits[k] <= HITS_ZERO;
      end
    end else begin
      state <= state_next;
      // loads: advance the fill count or flag the drop
      if (accept && items.opcode == OP_LOAD_TGT) begin
        if (tgt_we) begin
          tgt_cnt <= tgt_cnt + TC_W'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (accept && items.opcode == OP_LOAD_SRC) begin
        if (src_we) begin
          src_cnt <= src_cnt + SC_W'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (state == S_RUN_INIT) begin
        ti <= '0;
        sj <= '0;
        for (int k = 0; k < MAX_TARGETS; k++) begin
          thits[k] <= HITS_ZERO;
        end
        for (int k = 0; k < MAX_SOURCES; k++) begin
          shits[k] <= HITS_ZERO;
        end
      end
      if (state == S_CMP) begin
        if (hit) begin
          thits[ti] <= hits_inc(thits[ti]);
          shits[sj] <= hits_inc(shits[sj]);
        end
        if (last_src) begin
          sj <= '0;
          ti <= last_tgt ? '0 : ti + TI_W'(1);
        end else begin
          sj <= sj + SI_W'(1);
        end
      end
      if (out_load && !last_tgt) begin
        ti <= ti + TI_W'(1);
      end
      if (state == S_CLEAR) begin
        tgt_cnt <= '0;
        src_cnt <= '0;
        ovf     <= 1'b0;
      end
    end
  end

  // last matching source of each target
  always_ff @(posedge clk) begin
    if (state == S_CMP && hit) begin
      cand[ti] <= sj;
    end
  end

  // result for target ti
  always_comb begin
    new_status = ST_NONE;
    new_label  = '0;
    new_sidx   = '1;
    if (thits[ti] != HITS_ZERO) begin
      new_status = ST_AMBIG;
      if (thits[ti] == HITS_ONE && shits[s_raddr] == HITS_ONE) begin
        if (s_flav == '0) begin
          new_status = ST_EMPTY;
        end else begin
          new_status = ST_MATCHED;
          new_label  = s_flav;
          new_sidx   = SIDX_W'(s_raddr);
        end
      end
    end
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_tidx   <= TIDX_W'(ti);
      res_label  <= new_label;
      res_status <= new_status;
      res_sidx   <= new_sidx;
      res_ovf    <= ovf;
      res_last   <= last_tgt;
    end
  end

  assign results.valid        = res_valid;
  assign results.target_index = res_tidx;
  assign results.label        = res_label;
  assign results.status       = res_status;
  assign results.source_index = res_sidx;
  assign results.overflow     = res_ovf;
  assign results.last         = res_last;

`ifndef SYNTHESIS
  a_matched_fields: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status == ST_MATCHED) |-> (res_label != '0 && !res_sidx[SIDX_W-1]))
    else $error("matched result without label or source index");
  a_unmatched_fields: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status != ST_MATCHED) |-> (res_label == '0 && res_sidx == '1))
    else $error("unmatched result carries a label or source index");
  a_clear_after_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |=> (tgt_cnt == '0 && src_cnt == '0 && !ovf))
    else $error("loaded counts not cleared after run");
  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    (tgt_cnt <= TC_W'(MAX_TARGETS)) && (src_cnt <= SC_W'(MAX_SOURCES)))
    else $error("fill count beyond capacity");
`endif

endmodule
